>>> hw/rtl/sdat_pkg.sv
// Shared types, codes and constants of the sorted daily alarm table.
package sdat_pkg;

  // Default table depth.
  localparam int unsigned MaxAlarmsDef = 10;

  // Field widths of one alarm entry and of the input item.
  localparam int unsigned HourW   = 5;
  localparam int unsigned MinuteW = 6;
  localparam int unsigned AmountW = 8;
  localparam int unsigned SlotW   = 4;
  localparam int unsigned CountOutW = 4;
  localparam int unsigned MinsW   = 11;

  // Time arithmetic runs on 13-bit two's complement values.
  localparam int unsigned TimeW = 13;
  localparam logic [TimeW-1:0] MinPerDay = 13'd1440;
  localparam logic [MinsW-1:0] MinsSat   = 11'd2047;

  // Command codes of the input item.
  localparam logic [1:0] CMD_INSERT = 2'd0;
  localparam logic [1:0] CMD_REMOVE = 2'd1;
  localparam logic [1:0] CMD_RETIME = 2'd2;
  localparam logic [1:0] CMD_TICK   = 2'd3;

  // Operation broadcast to every cell of the chain.
  typedef enum logic [1:0] {
    OP_HOLD,
    OP_INSERT,
    OP_REMOVE,
    OP_TICK
  } cell_op_e;

  // One stored alarm.
  typedef struct packed {
    logic [HourW-1:0]   hour;
    logic [MinuteW-1:0] minute;
    logic [AmountW-1:0] amount;
    logic               fired;
  } entry_t;

  // Control word shared by all cells.
  typedef struct packed {
    cell_op_e           op;
    logic [HourW-1:0]   hour;
    logic [MinuteW-1:0] minute;
    logic [AmountW-1:0] amount;
  } cell_ctl_t;

  // Priority flags rippled from each cell to the next one.
  typedef struct packed {
    logic ge;          // this or an earlier cell is at or past the insert point
    logic seen_later;  // an earlier valid cell is later than the given time
    logic seen_fire;   // an earlier cell fires on this tick
    logic seen_rearm;  // an earlier cell re-arms on this tick
  } chain_t;

  // Per-cell match flags collected by the top level.
  typedef struct packed {
    logic dup_hit;
    logic fire_hit;
    logic next_hit;
  } cell_stat_t;

endpackage

>>> hw/rtl/sdat_cell.sv
// One cell of the alarm chain: holds one entry and shifts with its neighbors.
module sdat_cell import sdat_pkg::*; (
  input  logic       clk_i,
  input  logic       rst_ni,
  input  cell_ctl_t  ctl_i,
  input  logic       valid_i,
  input  logic       past_slot_i,
  input  entry_t     left_i,
  input  entry_t     right_i,
  input  chain_t     chain_i,
  output entry_t     entry_o,
  output chain_t     chain_o,
  output cell_stat_t stat_o
);

  entry_t entry_q, entry_d;
  logic   same_time, later, rearm_time, ge;
  logic   fire_hit, rearm_hit;

  // Compare the stored time with the broadcast time.
  always_comb begin
    same_time  = (entry_q.hour == ctl_i.hour) && (entry_q.minute == ctl_i.minute);
    later      = (entry_q.hour > ctl_i.hour) ||
                 ((entry_q.hour == ctl_i.hour) && (entry_q.minute > ctl_i.minute));
    rearm_time = (entry_q.hour == ctl_i.hour) &&
                 ({1'b0, entry_q.minute} == ({1'b0, ctl_i.minute} + 7'd1));
    ge         = chain_i.ge | ~valid_i | later;
    fire_hit   = valid_i & same_time & ~entry_q.fired & ~chain_i.seen_fire;
    rearm_hit  = valid_i & entry_q.fired & rearm_time & ~chain_i.seen_rearm;
  end

  // Pass the priority flags on to the next cell.
  always_comb begin
    chain_o.ge         = ge;
    chain_o.seen_later = chain_i.seen_later | (valid_i & later);
    chain_o.seen_fire  = chain_i.seen_fire | fire_hit;
    chain_o.seen_rearm = chain_i.seen_rearm | rearm_hit;
    stat_o.dup_hit     = valid_i & same_time;
    stat_o.fire_hit    = fire_hit;
    stat_o.next_hit    = valid_i & later & ~chain_i.seen_later;
  end

  // Next content of the cell for each operation.
  always_comb begin
    entry_d = entry_q;
    case (ctl_i.op)
      OP_INSERT: begin
        if (chain_i.ge) begin
          entry_d = left_i;
        end else if (ge) begin
          entry_d.hour   = ctl_i.hour;
          entry_d.minute = ctl_i.minute;
          entry_d.amount = ctl_i.amount;
          entry_d.fired  = 1'b0;
        end
      end
      OP_REMOVE: begin
        if (past_slot_i) begin
          entry_d = right_i;
        end
      end
      OP_TICK: begin
        if (fire_hit) begin
          entry_d.fired = 1'b1;
        end else if (rearm_hit) begin
          entry_d.fired = 1'b0;
        end
      end
      default: begin
        entry_d = entry_q;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      entry_q <= '0;
    end else begin
      entry_q <= entry_d;
    end
  end

  assign entry_o = entry_q;

endmodule

>>> hw/rtl/sdat_next_time.sv
// Minutes from the tick time to the next alarm, saturated to the output range.
module sdat_next_time import sdat_pkg::*; (
  input  logic [HourW-1:0]   now_hour_i,
  input  logic [MinuteW-1:0] now_minute_i,
  input  logic [HourW-1:0]   tgt_hour_i,
  input  logic [MinuteW-1:0] tgt_minute_i,
  input  logic               wrap_i,
  output logic [MinsW-1:0]   minutes_o
);

  logic [TimeW-1:0] now_t, tgt_t, diff;

  // Hour times sixty is built as a shift by six less a shift by two.
  always_comb begin
    now_t = {2'b0, now_hour_i, 6'b0} - {6'b0, now_hour_i, 2'b0} + {7'b0, now_minute_i};
    tgt_t = {2'b0, tgt_hour_i, 6'b0} - {6'b0, tgt_hour_i, 2'b0} + {7'b0, tgt_minute_i};
    diff  = tgt_t + (wrap_i ? MinPerDay : '0) - now_t;
  end

  // Clamp below at zero and above at the largest output value.
  always_comb begin
    if (diff[TimeW-1]) begin
      minutes_o = '0;
    end else if (diff[TimeW-2:MinsW] != '0) begin
      minutes_o = MinsSat;
    end else begin
      minutes_o = diff[MinsW-1:0];
    end
  end

endmodule

>>> hw/rtl/sorted_daily_alarm_table.sv
// Top level of the sorted daily alarm table: control sequencer and cell chain.
//
// The table keeps up to MAX_ALARMS daily alarms sorted by time of day in a
// chain of cells, one entry per cell. Every command but a retime is carried
// out in one pass over the chain, where each cell decides its next content
// from its own entry, its two neighbors and priority flags rippled down the
// chain. An insert, remove or minute tick goes through the chain update, then
// the result load; a retime has one more step, because its remove and its
// insert are two passes of the chain. The input stalls from a transfer until
// its result is loaded into the output register, so a new item is taken only
// when the previous one is through. The next item is taken once the result
// is in the output register, and that register may still be waiting for its
// transfer. A result is held back only while the previous one has not been
// taken.
module sorted_daily_alarm_table import sdat_pkg::*; #(
  parameter int unsigned MAX_ALARMS = MaxAlarmsDef
) (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 in_valid_i,
  output logic                 in_stall_o,
  input  logic [1:0]           command_i,
  input  logic [SlotW-1:0]     slot_i,
  input  logic [HourW-1:0]     hour_i,
  input  logic [MinuteW-1:0]   minute_i,
  input  logic [AmountW-1:0]   amount_i,
  output logic                 out_valid_o,
  input  logic                 out_stall_i,
  output logic                 accepted_o,
  output logic [CountOutW-1:0] entry_count_o,
  output logic                 duplicate_o,
  output logic                 fire_o,
  output logic [AmountW-1:0]   fire_amount_o,
  output logic                 has_next_o,
  output logic [MinsW-1:0]     minutes_to_next_o
);

  localparam int unsigned CW = $clog2(MAX_ALARMS + 1);
  localparam int unsigned SW = (CW > SlotW) ? CW : SlotW;

  localparam logic [1:0] ST_IDLE   = 2'd0;
  localparam logic [1:0] ST_EXEC   = 2'd1;
  localparam logic [1:0] ST_INSERT = 2'd2;
  localparam logic [1:0] ST_FINISH = 2'd3;

  logic [1:0]         state_q, state_d;
  logic [CW-1:0]      count_q, count_d;
  logic [1:0]         cmd_q;
  logic [SlotW-1:0]   slot_q;
  logic [HourW-1:0]   hour_q;
  logic [MinuteW-1:0] minute_q;
  logic [AmountW-1:0] amount_q, amount_d;

  // Result fields gathered during the chain pass.
  logic               res_acc_q, res_acc_d;
  logic               res_dup_q, res_dup_d;
  logic               res_fire_q, res_fire_d;
  logic [AmountW-1:0] res_famt_q, res_famt_d;
  logic               res_hasn_q, res_hasn_d;
  logic [HourW-1:0]   tgt_hour_q, tgt_hour_d;
  logic [MinuteW-1:0] tgt_min_q, tgt_min_d;
  logic               tgt_wrap_q, tgt_wrap_d;

  // Output register.
  logic                 out_valid_q, out_valid_d;
  logic                 out_acc_q;
  logic [CountOutW-1:0] out_count_q;
  logic                 out_dup_q;
  logic                 out_fire_q;
  logic [AmountW-1:0]   out_famt_q;
  logic                 out_hasn_q;
  logic [MinsW-1:0]     out_mins_q;
  logic                 out_load;

  cell_ctl_t  ctl;
  entry_t     entries [MAX_ALARMS];
  chain_t     chain   [MAX_ALARMS+1];
  cell_stat_t stats   [MAX_ALARMS];
  logic [MAX_ALARMS-1:0] cell_valid, at_slot, past_slot;

  logic               dup_any, fire_any, next_any;
  logic [AmountW-1:0] fire_amt, keep_amt;
  logic [HourW-1:0]   next_hour;
  logic [MinuteW-1:0] next_min;
  logic               slot_ok, room_ok;
  logic [MinsW-1:0]   calc_mins;

  logic in_xfer, out_xfer;

  assign in_stall_o = (state_q != ST_IDLE);
  assign in_xfer    = in_valid_i & ~in_stall_o;
  assign out_xfer   = out_valid_q & ~out_stall_i;

  // The cell chain.
  assign chain[0] = '0;

  for (genvar i = 0; i < MAX_ALARMS; i++) begin : g_cell
    entry_t left_e, right_e;

    assign cell_valid[i] = CW'(i) < count_q;
    assign at_slot[i]    = SW'(i) == SW'(slot_q);
    assign past_slot[i]  = SW'(i) >= SW'(slot_q);

    if (i == 0) begin : g_first
      assign left_e = '0;
    end else begin : g_inner_left
      assign left_e = entries[i-1];
    end

    if (i == MAX_ALARMS - 1) begin : g_last
      assign right_e = '0;
    end else begin : g_inner_right
      assign right_e = entries[i+1];
    end

    sdat_cell u_cell (
      .clk_i      (clk_i),
      .rst_ni     (rst_ni),
      .ctl_i      (ctl),
      .valid_i    (cell_valid[i]),
      .past_slot_i(past_slot[i]),
      .left_i     (left_e),
      .right_i    (right_e),
      .chain_i    (chain[i]),
      .entry_o    (entries[i]),
      .chain_o    (chain[i+1]),
      .stat_o     (stats[i])
    );
  end

  // Gather the per-cell matches; at most one cell raises the fire and next hit flags.
  always_comb begin
    dup_any   = 1'b0;
    fire_any  = 1'b0;
    next_any  = 1'b0;
    fire_amt  = '0;
    keep_amt  = '0;
    next_hour = '0;
    next_min  = '0;
    for (int i = 0; i < MAX_ALARMS; i++) begin
      dup_any  = dup_any | stats[i].dup_hit;
      fire_any = fire_any | stats[i].fire_hit;
      next_any = next_any | stats[i].next_hit;
      if (stats[i].fire_hit) begin
        fire_amt = fire_amt | entries[i].amount;
      end
      if (at_slot[i] && cell_valid[i]) begin
        keep_amt = keep_amt | entries[i].amount;
      end
      if (stats[i].next_hit) begin
        next_hour = next_hour | entries[i].hour;
        next_min  = next_min | entries[i].minute;
      end
    end
  end

  assign slot_ok = SW'(slot_q) < SW'(count_q);
  assign room_ok = count_q < CW'(MAX_ALARMS);

  // Sequencer: picks the chain operation and collects the result fields.
  always_comb begin
    state_d    = state_q;
    count_d    = count_q;
    amount_d   = amount_q;
    res_acc_d  = res_acc_q;
    res_dup_d  = res_dup_q;
    res_fire_d = res_fire_q;
    res_famt_d = res_famt_q;
    res_hasn_d = res_hasn_q;
    tgt_hour_d = tgt_hour_q;
    tgt_min_d  = tgt_min_q;
    tgt_wrap_d = tgt_wrap_q;
    out_load   = 1'b0;
    ctl.op     = OP_HOLD;
    ctl.hour   = hour_q;
    ctl.minute = minute_q;
    ctl.amount = amount_q;
    case (state_q)
      ST_IDLE: begin
        if (in_xfer) begin
          state_d = ST_EXEC;
        end
      end
      ST_EXEC: begin
        res_dup_d  = dup_any;
        res_fire_d = 1'b0;
        res_famt_d = '0;
        res_hasn_d = 1'b0;
        state_d    = ST_FINISH;
        case (cmd_q)
          CMD_INSERT: begin
            res_acc_d = room_ok;
            if (room_ok) begin
              ctl.op  = OP_INSERT;
              count_d = count_q + 1'b1;
            end
          end
          CMD_REMOVE: begin
            res_acc_d = slot_ok;
            if (slot_ok) begin
              ctl.op  = OP_REMOVE;
              count_d = count_q - 1'b1;
            end
          end
          CMD_RETIME: begin
            res_acc_d = slot_ok;
            if (slot_ok) begin
              ctl.op   = OP_REMOVE;
              count_d  = count_q - 1'b1;
              amount_d = keep_amt;
              state_d  = ST_INSERT;
            end
          end
          default: begin
            // Minute tick.
            ctl.op     = OP_TICK;
            res_acc_d  = 1'b1;
            res_fire_d = fire_any;
            res_famt_d = fire_amt;
            res_hasn_d = (count_q != '0);
            if (next_any) begin
              tgt_hour_d = next_hour;
              tgt_min_d  = next_min;
              tgt_wrap_d = 1'b0;
            end else begin
              tgt_hour_d = entries[0].hour;
              tgt_min_d  = entries[0].minute;
              tgt_wrap_d = 1'b1;
            end
          end
        endcase
      end
      ST_INSERT: begin
        // Second pass of a retime: put the entry back at its new time.
        ctl.op  = OP_INSERT;
        count_d = count_q + 1'b1;
        state_d = ST_FINISH;
      end
      default: begin
        // Hand the result to the output register once it is free.
        if (!out_valid_q || !out_stall_i) begin
          out_load = 1'b1;
          state_d  = ST_IDLE;
        end
      end
    endcase
  end

  sdat_next_time u_next_time (
    .now_hour_i  (hour_q),
    .now_minute_i(minute_q),
    .tgt_hour_i  (tgt_hour_q),
    .tgt_minute_i(tgt_min_q),
    .wrap_i      (tgt_wrap_q),
    .minutes_o   (calc_mins)
  );

  always_comb begin
    out_valid_d = out_valid_q;
    if (out_load) begin
      out_valid_d = 1'b1;
    end else if (out_xfer) begin
      out_valid_d = 1'b0;
    end
  end

  // Control state.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      count_q     <= '0;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      count_q     <= count_d;
      out_valid_q <= out_valid_d;
    end
  end

  // Item capture and result fields.
  always_ff @(posedge clk_i) begin
    if (in_xfer) begin
      cmd_q    <= command_i;
      slot_q   <= slot_i;
      hour_q   <= hour_i;
      minute_q <= minute_i;
      amount_q <= amount_i;
    end else begin
      amount_q <= amount_d;
    end
    res_acc_q  <= res_acc_d;
    res_dup_q  <= res_dup_d;
    res_fire_q <= res_fire_d;
    res_famt_q <= res_famt_d;
    res_hasn_q <= res_hasn_d;
    tgt_hour_q <= tgt_hour_d;
    tgt_min_q  <= tgt_min_d;
    tgt_wrap_q <= tgt_wrap_d;
    if (out_load) begin
      out_acc_q   <= res_acc_q;
      out_count_q <= CountOutW'(count_q);
      out_dup_q   <= res_dup_q;
      out_fire_q  <= res_fire_q;
      out_famt_q  <= res_famt_q;
      out_hasn_q  <= res_hasn_q;
      out_mins_q  <= res_hasn_q ? calc_mins : '0;
    end
  end

  assign out_valid_o       = out_valid_q;
  assign accepted_o        = out_acc_q;
  assign entry_count_o     = out_count_q;
  assign duplicate_o       = out_dup_q;
  assign fire_o            = out_fire_q;
  assign fire_amount_o     = out_famt_q;
  assign has_next_o        = out_hasn_q;
  assign minutes_to_next_o = out_mins_q;

`ifndef SYNTHESIS
  // The entry count never exceeds the table depth.
  a_count_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    count_q <= CW'(MAX_ALARMS))
    else $error("entry count exceeds table depth");

  // An insert into a table with room grows it by one entry.
  a_insert_grows: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == ST_EXEC && cmd_q == CMD_INSERT && room_ok)
    |=> count_q == CW'($past(count_q) + 1'b1))
    else $error("insert did not grow the table");

  // The second pass of a retime restores the count that its remove lowered.
  a_retime_insert: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == ST_INSERT) |=> count_q == CW'($past(count_q) + 1'b1))
    else $error("retime insert pass lost an entry");

  // A fired result only comes from an applied tick on a nonempty table.
  a_fire_is_tick: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_q && out_fire_q) |-> (out_acc_q && out_hasn_q))
    else $error("fire reported without a tick on a nonempty table");
`endif

endmodule

>>> verif/tb_sorted_daily_alarm_table.sv
// Self-checking testbench for the sorted daily alarm table: directed table, random traffic.
`timescale 1ns / 1ps

module tb_sorted_daily_alarm_table;
  import sdat_pkg::*;

  localparam int Depth       = MaxAlarmsDef;
  localparam int RandomItems = 750;
  localparam int MaxWait     = 18;
  localparam int DrainCycles = 20;

  // One command as presented on the input channel.
  typedef struct packed {
    logic [1:0]         command;
    logic [SlotW-1:0]   slot;
    logic [HourW-1:0]   hour;
    logic [MinuteW-1:0] minute;
    logic [AmountW-1:0] amount;
  } alarm_cmd_t;

  // One result as presented on the output channel.
  typedef struct packed {
    logic                 accepted;
    logic [CountOutW-1:0] entry_count;
    logic                 duplicate;
    logic                 fire;
    logic [AmountW-1:0]   fire_amount;
    logic                 has_next;
    logic [MinsW-1:0]     minutes_to_next;
  } alarm_res_t;

  // A row of the directed table; has_fixed marks rows with a typed-in result.
  typedef struct {
    alarm_cmd_t item;
    bit         has_fixed;
    alarm_res_t fixed_res;
  } plan_row_t;

  logic                 clk_i = 1'b0;
  logic                 rst_ni = 1'b0;
  logic                 in_valid_i = 1'b0;
  logic                 in_stall_o;
  logic [1:0]           command_i = CMD_TICK;
  logic [SlotW-1:0]     slot_i = '0;
  logic [HourW-1:0]     hour_i = '0;
  logic [MinuteW-1:0]   minute_i = '0;
  logic [AmountW-1:0]   amount_i = '0;
  logic                 out_valid_o;
  logic                 out_stall_i = 1'b0;
  logic                 accepted_o;
  logic [CountOutW-1:0] entry_count_o;
  logic                 duplicate_o;
  logic                 fire_o;
  logic [AmountW-1:0]   fire_amount_o;
  logic                 has_next_o;
  logic [MinsW-1:0]     minutes_to_next_o;

  sorted_daily_alarm_table u_dut (
    .clk_i             (clk_i),
    .rst_ni            (rst_ni),
    .in_valid_i        (in_valid_i),
    .in_stall_o        (in_stall_o),
    .command_i         (command_i),
    .slot_i            (slot_i),
    .hour_i            (hour_i),
    .minute_i          (minute_i),
    .amount_i          (amount_i),
    .out_valid_o       (out_valid_o),
    .out_stall_i       (out_stall_i),
    .accepted_o        (accepted_o),
    .entry_count_o     (entry_count_o),
    .duplicate_o       (duplicate_o),
    .fire_o            (fire_o),
    .fire_amount_o     (fire_amount_o),
    .has_next_o        (has_next_o),
    .minutes_to_next_o (minutes_to_next_o)
  );

  // Shadow copy of the alarm table kept by the predictor.
  logic [HourW-1:0]   slot_hour   [Depth] = '{default: '0};
  logic [MinuteW-1:0] slot_minute [Depth] = '{default: '0};
  logic [AmountW-1:0] slot_amount [Depth] = '{default: '0};
  logic               slot_fired  [Depth] = '{default: 1'b0};
  int                 entry_total = 0;

  alarm_res_t pending_results[$];
  plan_row_t  directed[$];
  int         mismatch_count = 0;
  bit         quiet_phase = 1'b0;
  int         out_hold_left = 0;

  // Clock and reset.
  initial begin
    forever #5 clk_i = ~clk_i;
  end

  initial begin
    repeat (10) @(posedge clk_i);
    rst_ni <= 1'b1;
  end

  // Watchdog in case the block hangs.
  initial begin
    #2_000_000;
    $display("[sorted_daily_alarm_table] ERROR");
    $finish;
  end

  // Time of day of a stored entry in minutes.
  function automatic int entry_tod(input int i);
    return int'(slot_hour[i]) * 60 + int'(slot_minute[i]);
  endfunction

  // Hour first, then minute.
  function automatic bit is_later(input int i, input int h, input int m);
    return int'(slot_hour[i]) > h || (int'(slot_hour[i]) == h && int'(slot_minute[i]) > m);
  endfunction

  // Sorted insert; equal times go after the entries already present.
  function automatic bit table_insert(input logic [HourW-1:0] h,
                                      input logic [MinuteW-1:0] m,
                                      input logic [AmountW-1:0] a);
    int pos;
    int i;
    if (entry_total >= Depth) return 1'b0;
    pos = entry_total;
    for (i = 0; i < entry_total; i++) begin
      if (is_later(i, h, m)) begin
        pos = i;
        break;
      end
    end
    for (i = entry_total; i > pos; i--) begin
      slot_hour[i]   = slot_hour[i-1];
      slot_minute[i] = slot_minute[i-1];
      slot_amount[i] = slot_amount[i-1];
      slot_fired[i]  = slot_fired[i-1];
    end
    slot_hour[pos]   = h;
    slot_minute[pos] = m;
    slot_amount[pos] = a;
    slot_fired[pos]  = 1'b0;
    entry_total++;
    return 1'b1;
  endfunction

  // Remove one entry, shift the later ones up and clear the freed slot.
  function automatic void table_remove(input int s);
    int i;
    for (i = s; i + 1 < entry_total; i++) begin
      slot_hour[i]   = slot_hour[i+1];
      slot_minute[i] = slot_minute[i+1];
      slot_amount[i] = slot_amount[i+1];
      slot_fired[i]  = slot_fired[i+1];
    end
    entry_total--;
    slot_hour[entry_total]   = '0;
    slot_minute[entry_total] = '0;
    slot_amount[entry_total] = '0;
    slot_fired[entry_total]  = 1'b0;
  endfunction

  // Applies one command to the shadow table and returns the result it gives.
  function automatic alarm_res_t alarm_table_update(input alarm_cmd_t c);
    alarm_res_t r;
    int i;
    int k;
    int now_tod;
    int span;
    logic [AmountW-1:0] keep;
    r = '0;
    r.accepted = 1'b1;
    for (i = 0; i < entry_total; i++) begin
      if (slot_hour[i] == c.hour && slot_minute[i] == c.minute) begin
        r.duplicate = 1'b1;
        break;
      end
    end
    case (c.command)
      CMD_INSERT: begin
        r.accepted = table_insert(c.hour, c.minute, c.amount);
      end
      CMD_REMOVE, CMD_RETIME: begin
        if (int'(c.slot) < entry_total) begin
          keep = slot_amount[c.slot];
          table_remove(int'(c.slot));
          if (c.command == CMD_RETIME) void'(table_insert(c.hour, c.minute, keep));
        end else begin
          r.accepted = 1'b0;
        end
      end
      default: begin
        // Fire the first due entry that has not fired yet.
        for (i = 0; i < entry_total; i++) begin
          if (slot_hour[i] == c.hour && slot_minute[i] == c.minute && !slot_fired[i]) begin
            r.fire        = 1'b1;
            r.fire_amount = slot_amount[i];
            slot_fired[i] = 1'b1;
            break;
          end
        end
        // Re-arm the first fired entry one minute ahead; no wrap past minute 59.
        for (i = 0; i < entry_total; i++) begin
          if (slot_fired[i] && slot_hour[i] == c.hour &&
              int'(slot_minute[i]) == int'(c.minute) + 1) begin
            slot_fired[i] = 1'b0;
            break;
          end
        end
        // Distance to the next alarm, wrapping to entry 0 tomorrow.
        if (entry_total > 0) begin
          now_tod = int'(c.hour) * 60 + int'(c.minute);
          k = entry_total;
          for (i = 0; i < entry_total; i++) begin
            if (is_later(i, c.hour, c.minute)) begin
              k = i;
              break;
            end
          end
          if (k < entry_total) span = entry_tod(k) - now_tod;
          else span = 1440 + entry_tod(0) - now_tod;
          if (span < 0) span = 0;
          if (span > 2047) span = 2047;
          r.has_next        = 1'b1;
          r.minutes_to_next = MinsW'(span);
        end
      end
    endcase
    r.entry_count = CountOutW'(entry_total);
    return r;
  endfunction

  function automatic alarm_res_t res_of(input bit acc, input int cnt, input bit dup,
                                        input bit fire, input int famt, input bit hn,
                                        input int mins);
    alarm_res_t r;
    r.accepted        = acc;
    r.entry_count     = CountOutW'(cnt);
    r.duplicate       = dup;
    r.fire            = fire;
    r.fire_amount     = AmountW'(famt);
    r.has_next        = hn;
    r.minutes_to_next = MinsW'(mins);
    return r;
  endfunction

  function automatic plan_row_t plan_row(input logic [1:0] cmd, input int s, input int h,
                                         input int m, input int a, input bit fixed,
                                         input alarm_res_t r);
    plan_row_t row;
    row.item.command = cmd;
    row.item.slot    = SlotW'(s);
    row.item.hour    = HourW'(h);
    row.item.minute  = MinuteW'(m);
    row.item.amount  = AmountW'(a);
    row.has_fixed    = fixed;
    row.fixed_res    = r;
    return row;
  endfunction

  // Random time, biased toward stored times and the minute before them.
  function automatic logic [HourW+MinuteW-1:0] pick_time();
    int sel;
    int j;
    logic [HourW-1:0]   h;
    logic [MinuteW-1:0] m;
    sel = $urandom_range(0, 99);
    h = HourW'($urandom_range(0, 23));
    m = MinuteW'($urandom_range(0, 59));
    if (entry_total > 0 && sel < 55) begin
      j = $urandom_range(0, entry_total - 1);
      h = slot_hour[j];
      m = slot_minute[j];
      if (sel >= 40 && m != 0) m = m - 1'b1;
    end else if (sel < 68) begin
      case ($urandom_range(0, 3))
        0: begin h = '0; m = '0; end
        1: begin h = HourW'(23); m = MinuteW'(59); end
        2: m = MinuteW'(59);
        default: m = '0;
      endcase
    end
    return {h, m};
  endfunction

  // Random command; grow phases favor inserts, the others removals.
  function automatic alarm_cmd_t random_item(input bit grow);
    alarm_cmd_t c;
    int sel;
    sel = $urandom_range(0, 99);
    if (grow) begin
      c.command = (sel < 45) ? CMD_INSERT : (sel < 55) ? CMD_REMOVE :
                  (sel < 65) ? CMD_RETIME : CMD_TICK;
    end else begin
      c.command = (sel < 15) ? CMD_INSERT : (sel < 50) ? CMD_REMOVE :
                  (sel < 65) ? CMD_RETIME : CMD_TICK;
    end
    {c.hour, c.minute} = pick_time();
    sel = $urandom_range(0, 99);
    if (entry_total > 0 && sel < 80) c.slot = SlotW'($urandom_range(0, entry_total - 1));
    else if (sel < 96) c.slot = SlotW'($urandom_range(0, Depth - 1));
    else c.slot = SlotW'($urandom_range(Depth, 15));
    c.amount = AmountW'($urandom_range(0, 255));
    return c;
  endfunction

  task automatic compare_field(input string name, input int unsigned want,
                               input int unsigned got);
    if (want != got) begin
      $error("%s: expected %0d, got %0d", name, want, got);
      mismatch_count++;
    end
  endtask

  // Output side: check each result transfer and draw the stall before the next one.
  always @(posedge clk_i) begin
    alarm_res_t want;
    if (rst_ni) begin
      if (out_valid_o && !out_stall_i) begin
        if (pending_results.size() == 0) begin
          $error("result transfer with no result expected");
          mismatch_count++;
        end else begin
          want = pending_results.pop_front();
          compare_field("accepted", want.accepted, accepted_o);
          compare_field("entry_count", want.entry_count, entry_count_o);
          compare_field("duplicate", want.duplicate, duplicate_o);
          compare_field("fire", want.fire, fire_o);
          compare_field("fire_amount", want.fire_amount, fire_amount_o);
          compare_field("has_next", want.has_next, has_next_o);
          compare_field("minutes_to_next", want.minutes_to_next, minutes_to_next_o);
        end
        out_hold_left = quiet_phase ? 0 : $urandom_range(0, MaxWait);
      end else if (out_valid_o && out_hold_left > 0) begin
        out_hold_left--;
      end
      out_stall_i <= (out_hold_left > 0);
    end
  end

  // Input side: directed table first, then random traffic.
  initial begin
    plan_row_t  row;
    alarm_res_t got;
    int         total;
    int         n;
    int         r;
    int         gap;

    // Empty table: tick, bad remove, bad retime.
    directed.push_back(plan_row(CMD_TICK,   0,  0,  0,   0, 1, res_of(1, 0, 0, 0, 0, 0, 0)));
    directed.push_back(plan_row(CMD_REMOVE, 0,  0,  0,   0, 1, res_of(0, 0, 0, 0, 0, 0, 0)));
    directed.push_back(plan_row(CMD_RETIME, 9, 23, 59,   0, 1, res_of(0, 0, 0, 0, 0, 0, 0)));
    // Single entry: fire with a full-day wrap, then re-arm from the minute before.
    directed.push_back(plan_row(CMD_INSERT, 0, 23, 59, 255, 1, res_of(1, 1, 0, 0, 0, 0, 0)));
    directed.push_back(plan_row(CMD_TICK,   0, 23, 59,   0, 1,
                                res_of(1, 1, 1, 1, 255, 1, 1440)));
    directed.push_back(plan_row(CMD_TICK,   0, 23, 58,   0, 1, res_of(1, 1, 0, 0, 0, 1, 1)));
    directed.push_back(plan_row(CMD_INSERT, 0,  0,  0,   0, 1, res_of(1, 2, 0, 0, 0, 0, 0)));
    // Equal times: order of insertion, firing one at a time, re-arm of the first.
    directed.push_back(plan_row(CMD_INSERT, 0, 12, 30, 'hA5, 0, '0));
    directed.push_back(plan_row(CMD_INSERT, 0, 12, 30, 'h5A, 0, '0));
    directed.push_back(plan_row(CMD_TICK,   0, 12, 30,   0, 0, '0));
    directed.push_back(plan_row(CMD_TICK,   0, 12, 30,   0, 0, '0));
    directed.push_back(plan_row(CMD_TICK,   0, 12, 29,   0, 0, '0));
    // Removal carries the fired flag of the shifted entry.
    directed.push_back(plan_row(CMD_REMOVE, 1, 12, 30,   0, 0, '0));
    directed.push_back(plan_row(CMD_TICK,   0, 12, 29,   0, 0, '0));
    // A tick at minute 59 does not re-arm the next hour.
    directed.push_back(plan_row(CMD_INSERT, 0,  1,  0,   7, 0, '0));
    directed.push_back(plan_row(CMD_TICK,   0,  1,  0,   0, 0, '0));
    directed.push_back(plan_row(CMD_TICK,   0,  0, 59,   0, 0, '0));
    directed.push_back(plan_row(CMD_RETIME, 0, 23, 59,   0, 0, '0));
    // Fill the table, then an insert on a full table and a bad slot.
    directed.push_back(plan_row(CMD_INSERT, 0,  6, 15,   1, 0, '0));
    directed.push_back(plan_row(CMD_INSERT, 0,  8,  0, 128, 0, '0));
    directed.push_back(plan_row(CMD_INSERT, 0, 18, 45,  64, 0, '0));
    directed.push_back(plan_row(CMD_INSERT, 0, 20, 20,   2, 0, '0));
    directed.push_back(plan_row(CMD_INSERT, 0, 23,  0, 254, 0, '0));
    directed.push_back(plan_row(CMD_INSERT, 0,  0,  1,   3, 0, '0));
    directed.push_back(plan_row(CMD_INSERT, 0, 17, 17,  99, 1,
                                res_of(0, 10, 0, 0, 0, 0, 0)));
    directed.push_back(plan_row(CMD_REMOVE, 10, 17, 17,  0, 1,
                                res_of(0, 10, 0, 0, 0, 0, 0)));
    directed.push_back(plan_row(CMD_REMOVE, 9, 12, 30,   0, 0, '0));

    wait (rst_ni);
    @(posedge clk_i);
    total = directed.size() + RandomItems;
    for (n = 0; n < total; n++) begin
      if (n < directed.size()) begin
        row = directed[n];
      end else begin
        r = n - directed.size();
        quiet_phase   = ((r / 45) % 4 == 3);
        row.item      = random_item((r / 60) % 2 == 0);
        row.has_fixed = 1'b0;
        row.fixed_res = '0;
      end

      // Idle gap before this transfer; valid stays high when there is none.
      gap = quiet_phase ? 0 : $urandom_range(0, MaxWait);
      if (gap > 0) begin
        in_valid_i <= 1'b0;
        repeat (gap) @(posedge clk_i);
      end
      in_valid_i <= 1'b1;
      command_i  <= row.item.command;
      slot_i     <= row.item.slot;
      hour_i     <= row.item.hour;
      minute_i   <= row.item.minute;
      amount_i   <= row.item.amount;
      do @(posedge clk_i); while (in_stall_o);

      // Transfer taken at this edge: update the shadow table.
      got = alarm_table_update(row.item);
      pending_results.push_back(row.has_fixed ? row.fixed_res : got);
    end
    in_valid_i <= 1'b0;

    // Drain the outstanding results, then let the pipeline settle.
    while (pending_results.size() != 0) @(posedge clk_i);
    repeat (DrainCycles) @(posedge clk_i);
    if (mismatch_count == 0) begin
      $display("[sorted_daily_alarm_table] OK");
    end else begin
      $display("[sorted_daily_alarm_table] ERROR");
    end
    $finish;
  end

endmodule
